// ===== hw/rtl/dnsqe_pkg.sv =====
// Shared constants, codes and types of the DNS query name extractor.
package dnsqe_pkg;

   localparam int MAX_PACKET_BYTES = 512;
   localparam int HEADER_BYTES     = 12;
   localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_LABEL  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] name_char;
      logic       is_end;
      status_type parse_status;
   } result_type;

   // Up to two results per input item, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== hw/rtl/dnsqe_parser.sv =====
// Packet walker: header skip, label decoding and end status for each input item.
module dnsqe_parser
   import dnsqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] packet_byte,
   input  logic       last_byte,
   output push_type   push
);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       label_ff, label_in;
   logic             seen_ff, seen_in;

   logic             emit;
   logic [7:0]       emit_char;
   status_type       status;
   result_type       char_res;
   result_type       end_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         label_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         label_ff <= label_in;
         seen_ff  <= seen_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      label_in  = label_ff;
      seen_in   = seen_ff;
      emit      = 1'b0;
      emit_char = packet_byte;
      status    = ST_OK;

      if (accept && (pos_ff < POS_W'(MAX_PACKET_BYTES))) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff >= POS_W'(HEADER_BYTES - 1)) phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (packet_byte == ZERO_BYTE) begin
                  phase_in = PH_DONE;
               end else begin
                  // A dot goes ahead of every label but the first.
                  if (seen_ff) begin
                     emit      = 1'b1;
                     emit_char = DOT_CHAR;
                  end
                  label_in = packet_byte;
                  phase_in = PH_LABEL;
                  seen_in  = 1'b1;
               end
            end
            PH_LABEL: begin
               emit     = 1'b1;
               label_in = label_ff - 8'd1;
               if (label_ff == 8'd1) phase_in = PH_LENGTH;
            end
            PH_DONE: begin
            end
         endcase
         pos_in = pos_ff + POS_W'(1);
      end

      if (phase_in == PH_LABEL) begin
         status = ST_ERROR;
      end else if ((phase_in == PH_HEADER) || !seen_in) begin
         status = ST_EMPTY;
      end

      // The last byte closes the packet and returns the walker to its start.
      if (accept && last_byte) begin
         phase_in = PH_HEADER;
         pos_in   = '0;
         label_in = '0;
         seen_in  = 1'b0;
      end
   end

   always_comb begin
      char_res.name_char    = emit_char;
      char_res.is_end       = 1'b0;
      char_res.parse_status = ST_OK;
      end_res.name_char     = ZERO_BYTE;
      end_res.is_end        = 1'b1;
      end_res.parse_status  = status;

      push.first  = emit ? char_res : end_res;
      push.second = end_res;
      push.count  = accept ? ({1'b0, emit} + {1'b0, last_byte}) : 2'd0;
   end

endmodule

// ===== hw/rtl/dnsqe_rsp_queue.sv =====
// Small result queue that takes up to two results a cycle and hands out one.
module dnsqe_rsp_queue
   import dnsqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output result_type head,
   output logic       head_valid,
   output logic       room
);

   result_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_next;
   logic              do_pop;

   assign do_pop  = pop && head_valid;
   assign wr_next = wr_ptr_ff + QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_next]   <= push.second;
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   // Room for the worst case of two results from the next item.
   assign room       = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

endmodule

// ===== hw/rtl/dns_query_name_extractor.sv =====
// Top level of the DNS query name extractor.
//
// The req_ channel carries one packet byte per item, with req_tlast set on the
// packet's final byte. The block skips the 12-byte header, decodes the
// length-prefixed labels of the query name and sends each name character as a
// result item on the rsp_ channel, with a dot before every label after the
// first. On the final byte it also sends an end item (rsp_tlast high) whose
// rsp_tuser gives the status: 0 name ok, 1 empty, 2 the packet ended inside a
// label, in which case the consumer drops the characters already sent.
// Bytes at position 512 and beyond are not decoded, but their tlast still
// closes the packet.
//
// The walker state updates in the same cycle the byte is accepted and its results
// are written into a four-entry result queue, so one byte can be accepted every
// cycle while req_tready is high. A byte yields at most two results; req_tready
// is high while the queue has room for two. Only a final byte yields two results,
// so with a ready receiver the queue never fills and throughput is one byte per
// cycle. When the receiver stalls the queue fills and req_tready drops. A
// synchronous reset empties the queue and returns the walker to the header phase.
module dns_query_name_extractor
   import dnsqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] packet_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] name_char
   output logic       rsp_tlast,   // is_end
   output logic [1:0] rsp_tuser    // [1:0] parse_status
);

   logic       accept;
   push_type   push;
   result_type head;
   logic       room;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   dnsqe_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .packet_byte (req_tdata),
      .last_byte   (req_tlast),
      .push        (push)
   );

   dnsqe_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .head       (head),
      .head_valid (rsp_tvalid),
      .room       (room)
   );

   assign rsp_tdata = head.name_char;
   assign rsp_tlast = head.is_end;
   assign rsp_tuser = head.parse_status;

endmodule

// ===== hw/rtl/dnsqe_checker.sv =====
// Port-level assertions for the DNS query name extractor, bound to the top level.
module dnsqe_checker
   import dnsqe_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // An end item never carries an undefined status code.
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tuser == ST_OK || rsp_tuser == ST_EMPTY
         || rsp_tuser == ST_ERROR) && rsp_tdata == ZERO_BYTE)
      else $error("bad end item");

   // Character items carry status zero.
   a_char_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == ST_OK)
      else $error("character item with nonzero status");

   // With nothing queued the block must be able to take a byte.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty queue");

endmodule

bind dns_query_name_extractor dnsqe_checker u_dnsqe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
